FILE: rtl/pwc_pkg.sv
// Shared types, constants and byte helpers for the pattern window compare block.
package pwc_pkg;

   localparam int PATTERN_DEPTH = 256;
   localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
   localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 1;
   localparam int MLEN_W        = 16;
   localparam int FCNT_W        = 32;

   localparam logic [7:0] SPACE_CHAR  = 8'h20;
   localparam logic [7:0] MASK_7BIT   = 8'h7f;
   localparam logic [7:0] MASK_8BIT   = 8'hff;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [CSR_INDEX_W-1:0] CSR_CASE_SENSITIVE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_PARITY     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_SPACE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHOLE_WORD       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_DELIMITED  = 3'd4;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_TEXT  = 2'd2,
      OP_END   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_MATCHING = 2'd1,
      PH_MATCHED  = 2'd2
   } phase_type;

   typedef struct packed {
      logic case_sensitive;
      logic strip_parity;
      logic ignore_space_runs;
      logic whole_word_check;
      logic space_delimited_words;
   } cfg_type;

   // one classified transaction as queued between front and back
   typedef struct packed {
      op_type     op;
      logic [7:0] data;        // raw byte for loads, masked/folded byte for text
      logic       first;
      logic       text_space;  // text byte at or below space
      logic       delim;       // text byte is a word delimiter
      logic       pre_ok;      // start: preceding byte check passed
   } cmd_type;

   function automatic logic [7:0] fold(input logic [7:0] c, input logic case_sens);
      logic [7:0] r;
      r = c;
      if (!case_sens && c >= 8'h61 && c <= 8'h7a) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_delim(input logic [7:0] c, input logic space_delim);
      logic alnum;
      alnum = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
              (c >= 8'h30 && c <= 8'h39);
      return space_delim ? (c <= SPACE_CHAR) : !alnum;
   endfunction

endpackage

FILE: rtl/pattern_window_compare.sv
// Top level of the pattern window compare block: CSRs, front end, queue and back end.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  func, data_byte, byte_present, pattern_first
//   rsp_      out        rsp_valid/rsp_stall  found, match_length, finds_total
//   csr_      in         csr_wr_en            csr_index, csr_wr_data
//
// One transaction per cycle through a 4-entry command queue, unless the queue is full or
// the back end is held by a pattern space run or a held result; a result is loaded into
// the rsp_ output register at the edge its transaction leaves the queue.
// A pattern whitespace run (ignore_space_runs) is walked one pattern byte at a time
// through the single read port of the pattern memory; the back end pops no transaction
// while it walks the run.
// A held result blocks only transactions that produce another result.
// Synchronous active-high reset; pattern memory is not cleared.
module pattern_window_compare (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_func,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_byte_present,
   input  logic                                  req_pattern_first,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [pwc_pkg::MLEN_W-1:0]            rsp_match_length,
   output logic [pwc_pkg::FCNT_W-1:0]            rsp_finds_total,
   input  logic                                  csr_wr_en,
   input  logic [pwc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pwc_pkg::CSR_DATA_W-1:0]        csr_wr_data
);

   pwc_pkg::cfg_type cfg_ff, cfg_in;
   pwc_pkg::cmd_type front_cmd;
   pwc_pkg::cmd_type q_head;
   logic             q_empty, q_full, q_pop, q_push;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pwc_pkg::CSR_CASE_SENSITIVE:  cfg_in.case_sensitive        = csr_wr_data[0];
            pwc_pkg::CSR_STRIP_PARITY:    cfg_in.strip_parity          = csr_wr_data[0];
            pwc_pkg::CSR_IGNORE_SPACE:    cfg_in.ignore_space_runs     = csr_wr_data[0];
            pwc_pkg::CSR_WHOLE_WORD:      cfg_in.whole_word_check      = csr_wr_data[0];
            pwc_pkg::CSR_SPACE_DELIMITED: cfg_in.space_delimited_words = csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   pwc_front u_front (
      .cfg               (cfg_ff),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .req_byte_present  (req_byte_present),
      .req_pattern_first (req_pattern_first),
      .cmd               (front_cmd)
   );

   pwc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   pwc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head             (q_head),
      .q_empty          (q_empty),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_length (rsp_match_length),
      .rsp_finds_total  (rsp_finds_total)
   );

endmodule

FILE: rtl/pwc_front.sv
// Front end: decodes an incoming transaction into a classified command.
module pwc_front (
   input  pwc_pkg::cfg_type cfg,
   input  logic [1:0]       req_func,
   input  logic [7:0]       req_data_byte,
   input  logic             req_byte_present,
   input  logic             req_pattern_first,
   output pwc_pkg::cmd_type cmd
);

   logic [7:0] masked;
   logic [7:0] folded;
   logic       masked_delim;

   always_comb begin
      masked       = req_data_byte & (cfg.strip_parity ? pwc_pkg::MASK_7BIT
                                                       : pwc_pkg::MASK_8BIT);
      folded       = pwc_pkg::fold(masked, cfg.case_sensitive);
      masked_delim = pwc_pkg::is_delim(masked, cfg.space_delimited_words);

      cmd.op         = pwc_pkg::op_type'(req_func);
      cmd.first      = req_pattern_first;
      cmd.text_space = (folded <= pwc_pkg::SPACE_CHAR);
      cmd.delim      = masked_delim;
      cmd.pre_ok     = req_byte_present ? masked_delim : 1'b1;
      case (cmd.op)
         pwc_pkg::OP_LOAD: begin
            cmd.data = req_data_byte;
         end
         default: begin
            cmd.data = folded;
         end
      endcase
   end

endmodule

FILE: rtl/pwc_queue.sv
// Small command FIFO that decouples the front end from the back end.
module pwc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pwc_pkg::cmd_type push_cmd,
   input  logic             pop,
   output pwc_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);

   pwc_pkg::cmd_type                  entry_ff [pwc_pkg::QUEUE_DEPTH];
   logic [pwc_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [pwc_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [pwc_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == pwc_pkg::QCNT_W'(pwc_pkg::QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/pwc_back.sv
// Back end: pattern memory, match state machine, find counter and result register.
module pwc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  pwc_pkg::cfg_type                  cfg,
   input  pwc_pkg::cmd_type                  head,
   input  logic                              q_empty,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [pwc_pkg::MLEN_W-1:0]        rsp_match_length,
   output logic [pwc_pkg::FCNT_W-1:0]        rsp_finds_total
);

   logic [7:0] pat_mem [pwc_pkg::PATTERN_DEPTH];
   logic [7:0] rd_data_ff;

   pwc_pkg::phase_type              phase_ff, phase_in;
   logic [pwc_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [pwc_pkg::LEN_W-1:0]       idx_ff, idx_in;
   logic [pwc_pkg::LEN_W-1:0]       idx_next;
   logic [pwc_pkg::MLEN_W-1:0]      cons_ff, cons_in, cons_bump;
   logic                            pre_ok_ff, pre_ok_in;
   logic                            skip_sp_ff, skip_sp_in;
   logic                            run_ff, run_in;     // walking a pattern space run
   logic [pwc_pkg::FCNT_W-1:0]      finds_ff, finds_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [pwc_pkg::MLEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic [pwc_pkg::FCNT_W-1:0]      rsp_total_ff, rsp_total_in;

   logic                            wr_en;
   logic [pwc_pkg::ADDR_W-1:0]      wr_addr;
   logic [pwc_pkg::LEN_W-1:0]       load_base;
   logic                            emit, hit, out_free;
   logic [7:0]                      pat_fold;
   logic                            pat_space;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_length = rsp_len_ff;
   assign rsp_finds_total  = rsp_total_ff;

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      cons_in    = cons_ff;
      pre_ok_in  = pre_ok_ff;
      skip_sp_in = skip_sp_ff;
      run_in     = run_ff;
      pop        = 1'b0;
      emit       = 1'b0;
      hit        = 1'b0;
      wr_en      = 1'b0;
      load_base  = head.first ? '0 : len_ff;
      wr_addr    = load_base[pwc_pkg::ADDR_W-1:0];
      out_free   = !rsp_valid_ff || !rsp_stall;
      idx_next   = idx_ff + 1'b1;
      cons_bump  = (cons_ff != '1) ? cons_ff + 1'b1 : cons_ff;
      pat_fold   = pwc_pkg::fold(rd_data_ff, cfg.case_sensitive);
      pat_space  = (rd_data_ff <= pwc_pkg::SPACE_CHAR);

      if (run_ff) begin
         // rd_data_ff holds the pattern byte at idx_ff
         if (pat_space) begin
            idx_in = idx_next;
            if (idx_next >= len_ff) begin
               phase_in   = pwc_pkg::PH_MATCHED;
               skip_sp_in = 1'b0;
               run_in     = 1'b0;
            end
         end else begin
            run_in = 1'b0;
         end
      end else if (!q_empty) begin
         pop = 1'b1;
         case (head.op)
            pwc_pkg::OP_LOAD: begin
               if (load_base < pwc_pkg::LEN_W'(pwc_pkg::PATTERN_DEPTH)) begin
                  wr_en  = 1'b1;
                  len_in = load_base + 1'b1;
               end else begin
                  len_in = load_base;
               end
               phase_in   = pwc_pkg::PH_IDLE;
               skip_sp_in = 1'b0;
            end
            pwc_pkg::OP_START: begin
               idx_in     = '0;
               cons_in    = '0;
               skip_sp_in = 1'b0;
               pre_ok_in  = head.pre_ok;
               phase_in   = (len_ff == '0) ? pwc_pkg::PH_MATCHED : pwc_pkg::PH_MATCHING;
            end
            pwc_pkg::OP_END: begin
               if (phase_ff == pwc_pkg::PH_MATCHING) begin
                  emit = 1'b1;
               end else if (phase_ff == pwc_pkg::PH_MATCHED) begin
                  emit = 1'b1;
                  hit  = !cfg.whole_word_check || pre_ok_ff;
               end
            end
            default: begin
               if (phase_ff == pwc_pkg::PH_MATCHED) begin
                  emit = 1'b1;
                  hit  = !cfg.whole_word_check || (pre_ok_ff && head.delim);
               end else if (phase_ff == pwc_pkg::PH_MATCHING) begin
                  if (skip_sp_ff && head.text_space) begin
                     cons_in = cons_bump;
                  end else begin
                     skip_sp_in = 1'b0;
                     if (idx_ff >= len_ff) begin
                        emit = 1'b1;
                     end else if (cfg.ignore_space_runs && pat_space) begin
                        if (!head.text_space) begin
                           emit = 1'b1;
                        end else begin
                           idx_in  = idx_next;
                           cons_in = cons_bump;
                           if (idx_next >= len_ff) begin
                              phase_in = pwc_pkg::PH_MATCHED;
                           end else begin
                              skip_sp_in = 1'b1;
                              run_in     = 1'b1;
                           end
                        end
                     end else if (pat_fold != head.data) begin
                        emit = 1'b1;
                     end else begin
                        idx_in  = idx_next;
                        cons_in = cons_bump;
                        if (idx_next >= len_ff) begin
                           phase_in = pwc_pkg::PH_MATCHED;
                        end
                     end
                  end
               end
            end
         endcase

         if (emit) begin
            phase_in   = pwc_pkg::PH_IDLE;
            skip_sp_in = 1'b0;
         end

         // result slot busy: hold this transaction in the queue
         if (emit && !out_free) begin
            phase_in   = phase_ff;
            len_in     = len_ff;
            idx_in     = idx_ff;
            cons_in    = cons_ff;
            pre_ok_in  = pre_ok_ff;
            skip_sp_in = skip_sp_ff;
            run_in     = run_ff;
            pop        = 1'b0;
            emit       = 1'b0;
            hit        = 1'b0;
         end
      end

      finds_in     = finds_ff + pwc_pkg::FCNT_W'(hit);
      rsp_found_in = hit;
      rsp_len_in   = hit ? cons_ff : '0;
      rsp_total_in = finds_in;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pwc_pkg::PH_IDLE;
         len_ff       <= '0;
         idx_ff       <= '0;
         cons_ff      <= '0;
         pre_ok_ff    <= 1'b1;
         skip_sp_ff   <= 1'b0;
         run_ff       <= 1'b0;
         finds_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         cons_ff      <= cons_in;
         pre_ok_ff    <= pre_ok_in;
         skip_sp_ff   <= skip_sp_in;
         run_ff       <= run_in;
         finds_ff     <= finds_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff <= rsp_found_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_total_ff <= rsp_total_in;
      end
   end

   // read address follows the next compare index so the byte is ready next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem[wr_addr] <= head.data;
      end
      rd_data_ff <= pat_mem[idx_in[pwc_pkg::ADDR_W-1:0]];
   end

endmodule

FILE: tb/pattern_window_compare_match_check.sv
// Result predictor and scoreboard for the pattern window compare block.
module pattern_window_compare_match_check
   import pwc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [1:0]             req_func,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_byte_present,
   input  logic                   req_pattern_first,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_found,
   input  logic [MLEN_W-1:0]      rsp_match_length,
   input  logic [FCNT_W-1:0]      rsp_finds_total,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                     verdict_errors,
   output int                     verdicts_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              found;
      logic [MLEN_W-1:0] length;
      logic [FCNT_W-1:0] total;
   } verdict_t;

   cfg_type           mode;
   logic [7:0]        pattern_mem [PATTERN_DEPTH];
   int                pattern_len;
   int                cmp_pos;
   logic [MLEN_W-1:0] covered;
   phase_type         phase;
   logic              lead_ok;
   logic              in_text_space;
   logic [FCNT_W-1:0] hit_count;
   verdict_t          pending_verdicts[$];
   verdict_t          want;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      if (!mode.case_sensitive && c >= "a" && c <= "z") begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [7:0] parity_mask(input logic [7:0] c);
      return mode.strip_parity ? (c & MASK_7BIT) : c;
   endfunction

   function automatic logic word_break(input logic [7:0] c);
      logic alnum;
      alnum = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
      return mode.space_delimited_words ? (c <= SPACE_CHAR) : !alnum;
   endfunction

   task automatic count_byte();
      if (covered != '1) begin
         covered = covered + 1'b1;
      end
   endtask

   task automatic close_candidate(input logic hit);
      verdict_t v;
      if (hit) begin
         hit_count = hit_count + 1'b1;
      end
      v.found  = hit;
      v.length = hit ? covered : '0;
      v.total  = hit_count;
      pending_verdicts.push_back(v);
      phase         = PH_IDLE;
      in_text_space = 1'b0;
   endtask

   task automatic track_item(input op_type op, input logic [7:0] b, input logic present,
                             input logic first);
      logic [7:0] c;
      logic [7:0] p;
      case (op)
         OP_LOAD: begin
            if (first) begin
               pattern_len = 0;
            end
            if (pattern_len < PATTERN_DEPTH) begin
               pattern_mem[pattern_len] = b;
               pattern_len++;
            end
            phase         = PH_IDLE;
            in_text_space = 1'b0;
         end
         OP_START: begin
            cmp_pos       = 0;
            covered       = '0;
            in_text_space = 1'b0;
            lead_ok       = present ? word_break(parity_mask(b)) : 1'b1;
            phase         = (pattern_len == 0) ? PH_MATCHED : PH_MATCHING;
         end
         OP_END: begin
            if (phase == PH_MATCHING) begin
               close_candidate(1'b0);
            end else if (phase == PH_MATCHED) begin
               close_candidate(!mode.whole_word_check || lead_ok);
            end
         end
         default: begin
            if (phase == PH_MATCHED) begin
               // the byte after the match decides the whole-word test
               close_candidate(!mode.whole_word_check ||
                               (lead_ok && word_break(parity_mask(b))));
            end else if (phase == PH_MATCHING) begin
               c = upcase(parity_mask(b));
               if (in_text_space && c <= SPACE_CHAR) begin
                  count_byte();
               end else begin
                  in_text_space = 1'b0;
                  if (cmp_pos >= pattern_len) begin
                     close_candidate(1'b0);
                  end else begin
                     p = pattern_mem[cmp_pos];
                     if (mode.ignore_space_runs && p <= SPACE_CHAR) begin
                        if (c > SPACE_CHAR) begin
                           close_candidate(1'b0);
                        end else begin
                           // whole pattern whitespace run is eaten by one text byte
                           while (cmp_pos < pattern_len && pattern_mem[cmp_pos] <= SPACE_CHAR)
                              cmp_pos++;
                           count_byte();
                           if (cmp_pos >= pattern_len) begin
                              phase = PH_MATCHED;
                           end else begin
                              in_text_space = 1'b1;
                           end
                        end
                     end else if (upcase(p) != c) begin
                        close_candidate(1'b0);
                     end else begin
                        cmp_pos++;
                        count_byte();
                        if (cmp_pos >= pattern_len) begin
                           phase = PH_MATCHED;
                        end
                     end
                  end
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode          = '0;
         pattern_len   = 0;
         cmp_pos       = 0;
         covered       = '0;
         phase         = PH_IDLE;
         lead_ok       = 1'b1;
         in_text_space = 1'b0;
         hit_count     = '0;
         verdict_errors = 0;
         pending_verdicts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               verdict_errors++;
               $display("%0t: result with nothing expected: found %0b length %0d total %0d",
                        $time, rsp_found, rsp_match_length, rsp_finds_total);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_found !== want.found) begin
                  verdict_errors++;
                  $display("%0t: found expected %0b actual %0b",
                           $time, want.found, rsp_found);
               end
               if (rsp_match_length !== want.length) begin
                  verdict_errors++;
                  $display("%0t: match_length expected %0d actual %0d",
                           $time, want.length, rsp_match_length);
               end
               if (rsp_finds_total !== want.total) begin
                  verdict_errors++;
                  $display("%0t: finds_total expected %0d actual %0d",
                           $time, want.total, rsp_finds_total);
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CASE_SENSITIVE:  mode.case_sensitive        = csr_wr_data[0];
               CSR_STRIP_PARITY:    mode.strip_parity          = csr_wr_data[0];
               CSR_IGNORE_SPACE:    mode.ignore_space_runs     = csr_wr_data[0];
               CSR_WHOLE_WORD:      mode.whole_word_check      = csr_wr_data[0];
               CSR_SPACE_DELIMITED: mode.space_delimited_words = csr_wr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            track_item(op_type'(req_func), req_data_byte, req_byte_present, req_pattern_first);
         end
      end
      verdicts_due <= pending_verdicts.size();
   end

endmodule

FILE: tb/pattern_window_compare_test.sv
// Stimulus and verdict for the pattern window compare block.
module pattern_window_compare_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pwc_pkg::*;

   localparam int ITEM_TARGET  = 1250;
   localparam int PHASE_ITEMS  = 110;
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int HOLD_CYCLES  = 80;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_func;
   logic [7:0]             req_data_byte;
   logic                   req_byte_present;
   logic                   req_pattern_first;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_found;
   logic [MLEN_W-1:0]      rsp_match_length;
   logic [FCNT_W-1:0]      rsp_finds_total;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   int         verdict_errors;
   int         verdicts_due;
   int         cycle_count;
   int         sent_items;
   int         stall_run;
   bit         quiet_req;
   bit         quiet_rsp;
   bit         long_hold;
   cfg_type    run_cfg;
   logic [7:0] pattern_copy[$];

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   pattern_window_compare dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .req_byte_present  (req_byte_present),
      .req_pattern_first (req_pattern_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_length  (rsp_match_length),
      .rsp_finds_total   (rsp_finds_total),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   pattern_window_compare_match_check match_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_data_byte     (req_data_byte),
      .req_byte_present  (req_byte_present),
      .req_pattern_first (req_pattern_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_match_length  (rsp_match_length),
      .rsp_finds_total   (rsp_finds_total),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .verdict_errors    (verdict_errors),
      .verdicts_due      (verdicts_due)
   );

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** pattern_window_compare: FAILED **");
      $finish;
   end

   // result side: short random stalls, now and then a long hold-off
   initial begin
      rsp_stall = 1'b0;
      stall_run = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet_rsp && $urandom_range(0, 9) < 3) begin
               case ($urandom_range(0, 19))
                  19:      stall_run = $urandom_range(15, 30);
                  15, 16,
                  17, 18:  stall_run = $urandom_range(3, 8);
                  default: stall_run = $urandom_range(1, 2);
               endcase
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 6))
         0:       return 8'($urandom_range("a", "z"));
         1:       return 8'($urandom_range("A", "Z"));
         2:       return 8'($urandom_range("0", "9"));
         3:       return 8'($urandom_range(0, SPACE_CHAR));
         4:       return 8'($urandom_range(8'h21, 8'h2f));
         5:       return 8'($urandom_range(8'h80, 8'hff));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_alnum();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range("a", "z"));
         1:       return 8'($urandom_range("A", "Z"));
         default: return 8'($urandom_range("0", "9"));
      endcase
   endfunction

   function automatic logic [7:0] space_text();
      logic [7:0] t;
      t = 8'($urandom_range(0, SPACE_CHAR));
      if (run_cfg.strip_parity && $urandom_range(0, 3) == 0) t = t | ~MASK_7BIT;
      return t;
   endfunction

   // a text byte that should compare equal to pattern byte p, unless p has bit 7 set and parity is stripped
   function automatic logic [7:0] text_for(input logic [7:0] p);
      logic [7:0] t;
      t = p;
      if (!run_cfg.case_sensitive && ((p >= "a" && p <= "z") || (p >= "A" && p <= "Z")) &&
          $urandom_range(0, 1)) begin
         t = t ^ CASE_OFFSET;
      end
      if (run_cfg.strip_parity && $urandom_range(0, 1)) t = t | ~MASK_7BIT;
      return t;
   endfunction

   function automatic int pick_len();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
   endfunction

   task automatic offer(input op_type op, input logic [7:0] b, input logic present,
                        input logic first);
      int gap;
      if (op == OP_LOAD) begin
         if (first) pattern_copy.delete();
         if (pattern_copy.size() < PATTERN_DEPTH) pattern_copy.push_back(b);
      end
      req_valid         <= 1'b1;
      req_func          <= op;
      req_data_byte     <= b;
      req_byte_present  <= present;
      req_pattern_first <= first;
      do @(posedge clock); while (req_stall);
      sent_items++;
      gap = quiet_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic idle_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic v);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v;
      @(posedge clock);
   endtask

   task automatic apply_cfg(input cfg_type c);
      run_cfg = c;
      write_reg(CSR_CASE_SENSITIVE, c.case_sensitive);
      write_reg(CSR_STRIP_PARITY, c.strip_parity);
      write_reg(CSR_IGNORE_SPACE, c.ignore_space_runs);
      write_reg(CSR_WHOLE_WORD, c.whole_word_check);
      write_reg(CSR_SPACE_DELIMITED, c.space_delimited_words);
      // unmapped indexes must leave every register alone
      for (int i = CSR_SPACE_DELIMITED + 1; i < (1 << CSR_INDEX_W); i++)
         write_reg(CSR_INDEX_W'(i), 1'($urandom_range(0, 1)));
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_pattern(input int len);
      for (int i = 0; i < len; i++)
         offer(OP_LOAD, pick_byte(), 1'($urandom_range(0, 1)), i == 0);
   endtask

   // one candidate: mostly text built from the pattern, some corrupt, short or random
   task automatic run_candidate();
      int         kind;
      int         i;
      int         j;
      int         cut;
      int         spot;
      logic [7:0] t;
      offer(OP_START, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
         repeat ($urandom_range(0, 6))
            offer(OP_TEXT, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
         cut  = (kind == 7) ? $urandom_range(0, pattern_copy.size() - 1) : pattern_copy.size();
         spot = (kind == 6) ? $urandom_range(0, pattern_copy.size() - 1) : -1;
         i = 0;
         while (i < cut) begin
            if (run_cfg.ignore_space_runs && pattern_copy[i] <= SPACE_CHAR) begin
               j = i;
               while (j < pattern_copy.size() && pattern_copy[j] <= SPACE_CHAR) j++;
               // a run at the tail of the pattern takes exactly one text byte
               repeat ((j == pattern_copy.size()) ? 1 : $urandom_range(1, 3))
                  offer(OP_TEXT, space_text(), 1'($urandom_range(0, 1)), 1'b0);
               i = j;
            end else begin
               t = (i == spot) ? pick_byte() : text_for(pattern_copy[i]);
               offer(OP_TEXT, t, 1'b0, 1'($urandom_range(0, 1)));
               i++;
            end
         end
      end
      case ($urandom_range(0, 3))
         0, 1: offer(OP_END, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         2:    offer(OP_TEXT, pick_byte(), 1'($urandom_range(0, 1)), 1'b0);
         default: begin
            offer(OP_TEXT, pick_byte(), 1'b1, 1'b1);
            offer(OP_END, 8'hff, 1'b1, 1'b1);
         end
      endcase
   endtask

   task automatic offer_noise();
      op_type op;
      op = op_type'($urandom_range(0, 3));
      offer(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
   endtask

   initial begin
      int      phase_no;
      int      random_start;
      int      phase_start;
      int      r;
      cfg_type c;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = OP_LOAD;
      req_data_byte     = '0;
      req_byte_present  = 1'b0;
      req_pattern_first = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_CASE_SENSITIVE;
      csr_wr_data       = '0;
      quiet_req         = 1'b0;
      quiet_rsp         = 1'b0;
      long_hold         = 1'b0;
      sent_items        = 0;
      run_cfg           = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, idle traffic, empty pattern, a 3-byte pattern, then a 1-byte pattern
      offer(OP_TEXT, 8'hff, 1'b1, 1'b1);
      offer(OP_END, 8'h00, 1'b0, 1'b0);
      offer(OP_START, "A", 1'b1, 1'b0);
      offer(OP_END, 8'h00, 1'b0, 1'b0);
      offer(OP_START, 8'h00, 1'b0, 1'b0);
      offer(OP_TEXT, "x", 1'b0, 1'b0);
      offer(OP_LOAD, "a", 1'b0, 1'b1);
      offer(OP_LOAD, "B", 1'b1, 1'b0);
      offer(OP_LOAD, 8'hff, 1'b0, 1'b0);
      offer(OP_START, 8'hff, 1'b1, 1'b0);
      offer(OP_TEXT, "A", 1'b0, 1'b0);
      offer(OP_TEXT, "b", 1'b0, 1'b0);
      offer(OP_TEXT, 8'hff, 1'b0, 1'b0);
      offer(OP_END, 8'h00, 1'b0, 1'b0);
      offer(OP_START, 8'h00, 1'b0, 1'b0);
      offer(OP_TEXT, "a", 1'b0, 1'b0);
      offer(OP_END, 8'h00, 1'b0, 1'b0);
      offer(OP_START, 8'h00, 1'b0, 1'b0);
      offer(OP_TEXT, "q", 1'b0, 1'b0);
      offer(OP_START, 8'h00, 1'b0, 1'b0);
      offer(OP_TEXT, "a", 1'b0, 1'b0);
      offer(OP_START, 8'h00, 1'b1, 1'b0);
      offer(OP_TEXT, "A", 1'b0, 1'b0);
      offer(OP_TEXT, "B", 1'b0, 1'b0);
      offer(OP_TEXT, 8'hff, 1'b0, 1'b0);
      offer(OP_TEXT, 8'h00, 1'b0, 1'b0);
      offer(OP_START, 8'h00, 1'b0, 1'b0);
      offer(OP_TEXT, "a", 1'b0, 1'b0);
      offer(OP_LOAD, 8'h00, 1'b0, 1'b1);
      offer(OP_START, 8'h00, 1'b0, 1'b0);
      offer(OP_TEXT, 8'h00, 1'b0, 1'b0);
      offer(OP_END, 8'h00, 1'b0, 1'b0);

      phase_no     = 0;
      random_start = sent_items;
      while (sent_items - random_start < ITEM_TARGET) begin
         idle_until_drained();
         if (phase_no == 0) c = '0;
         else if (phase_no == 1) c = '1;
         else c = cfg_type'(5'($urandom_range(0, 31)));
         apply_cfg(c);
         quiet_req = ($urandom_range(0, 3) == 0);
         quiet_rsp = ($urandom_range(0, 3) == 0);
         load_pattern(pick_len());

         if (phase_no == 2) begin
            // results back up behind a long receiver hold-off
            long_hold = 1'b1;
            quiet_req = 1'b1;
            repeat (12) begin
               offer(OP_START, pick_byte(), 1'($urandom_range(0, 1)), 1'b0);
               offer(OP_END, pick_byte(), 1'b0, 1'b0);
            end
            quiet_req = 1'b0;
         end
         if (phase_no == 3) begin
            // overfill the pattern store, then match against the full-length pattern
            for (int i = 0; i < PATTERN_DEPTH + 2; i++)
               offer(OP_LOAD, pick_alnum(), 1'($urandom_range(0, 1)), i == 0);
            repeat (2) run_candidate();
            load_pattern(pick_len());
         end

         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r < 2) offer_noise();
            else if (r < 3) load_pattern(pick_len());
            else run_candidate();
         end
         phase_no++;
      end

      idle_until_drained();
      if (verdict_errors == 0) begin
         $display("** pattern_window_compare: PASSED **");
      end else begin
         $display("** pattern_window_compare: FAILED **");
      end
      $finish;
   end

endmodule
